### design/ilha_pkg.sv
// Shared types and constants for the implicit-list heap allocator.
// Used by ilha_ctrl, ilha_dp and implicit_list_heap_allocator_core; no dependencies.
package ilha_pkg;

	// Defaults and fixed sizes
	localparam int HEAP_BYTES_DEF = 65536;
	localparam int WORD_W = 32;
	localparam logic [31:0] MIN_BLOCK = 32'd16;
	localparam logic [31:0] PAIR_BYTES = 32'd8;
	localparam logic [31:0] WORD_BYTES = 32'd4;
	localparam logic [31:0] SIZE_MASK = ~32'd7;
	localparam logic [31:0] USED_BIT = 32'd1;
	localparam logic [15:0] CHUNK_RESET = 16'd4096;

	// Action codes
	localparam logic [1:0] ACT_INIT = 2'd0;
	localparam logic [1:0] ACT_ALLOC = 2'd1;
	localparam logic [1:0] ACT_FREE = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OOM = 2'd2;
	localparam logic [1:0] ST_NOINIT = 2'd3;

	typedef enum logic [5:0] {
		S_IDLE, S_DISP,
		S_INI0, S_INI1, S_INI2, S_INI3,
		S_GR0, S_GR1, S_GR2,
		S_M0, S_M1, S_M2, S_M3, S_M4,
		S_MA, S_MB, S_MC0, S_MC1, S_MC2,
		S_FR, S_FW, S_MEND,
		S_FREE0, S_FREE1,
		S_SK0, S_SK1, S_NF,
		S_K0, S_K1, S_KS0, S_KS1,
		S_DONE
	} state_t;

	typedef enum logic [5:0] {
		CMD_NOP, CMD_LATCH, CMD_ST1, CMD_ST3, CMD_FAIL, CMD_TAKE, CMD_OUT,
		CMD_INI0, CMD_INI1, CMD_INI2, CMD_INI3,
		CMD_GR0, CMD_GR1, CMD_GR2,
		CMD_M0, CMD_M1, CMD_M2, CMD_M3, CMD_M4,
		CMD_MA, CMD_MB, CMD_MC0, CMD_MC1, CMD_MC2,
		CMD_FR, CMD_FW,
		CMD_FREE0, CMD_FREE1,
		CMD_SK0, CMD_SK1, CMD_NF,
		CMD_K0, CMD_K1, CMD_KS0, CMD_KS1
	} cmd_t;

	// Where to go after a footer write
	typedef enum logic [1:0] {
		FW_MERGE, FW_FREE, FW_CARVE_A, FW_CARVE_B
	} fw_ctx_t;

	// Who started the coalesce step
	typedef enum logic [1:0] {
		MC_INIT, MC_ALLOC, MC_FREE
	} merge_ctx_t;

	// Datapath flags seen by the controller
	typedef struct packed {
		logic grow_fail;
		logic seek_oob;
		logic seek_zero;
		logic seek_fit;
		logic seek_last;
		logic rused;
		logic pused;
		logic mret_zero;
		logic ready;
		logic req_zero;
		logic split;
	} dp_stat_t;

endpackage

### design/implicit_list_heap_allocator_core.sv
// Top level of the implicit-list heap allocator (boundary tags, first fit).
// Depends on ilha_pkg, ilha_ctrl and ilha_dp.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | action, request_size, block_addr
//  out     | out_valid / out_stall| result_addr, status
//  cfg     | cfg_we               | cfg_data (extend_chunk)
//
// One request at a time; one memory access per cycle, read data registered.
// An init writes the prologue and epilogue, then grows the break by one
// chunk; a free clears the used bit and coalesces; an allocate walks the
// blocks first fit, grows the break when none fits and splits a large one.
// Reset: no clearing pass. The input stalls until the result is loaded; a
// finished result waits while the output register holds an unaccepted one.
module implicit_list_heap_allocator_core #(
	parameter int HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] request_size,
	input  logic [15:0] block_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] result_addr,
	output logic [1:0]  status
);

	ilha_pkg::cmd_t cmd;
	ilha_pkg::dp_stat_t st;

	// Sequencer
	ilha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Heap memory and arithmetic
	ilha_dp #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.action      (action),
		.request_size(request_size),
		.block_addr  (block_addr),
		.result_addr (result_addr),
		.status      (status)
	);

endmodule

### design/ilha_ctrl.sv
// Sequencer for the heap allocator: walks init, grow, coalesce, free, seek and carve steps.
// Depends on ilha_pkg; drives ilha_dp through a command code.
module ilha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	output logic              out_valid,
	input  logic              out_stall,
	input  ilha_pkg::dp_stat_t st,
	output ilha_pkg::cmd_t    cmd
);

	ilha_pkg::state_t state_q, state_d;
	ilha_pkg::fw_ctx_t fctx_q, fctx_d;
	ilha_pkg::merge_ctx_t mctx_q, mctx_d;
	logic [1:0] act_q;
	logic out_valid_q, out_valid_d;

	assign in_stall = (state_q != ilha_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	// State and context registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilha_pkg::S_IDLE;
			fctx_q <= ilha_pkg::FW_MERGE;
			mctx_q <= ilha_pkg::MC_INIT;
			act_q <= ilha_pkg::ACT_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fctx_q <= fctx_d;
			mctx_q <= mctx_d;
			out_valid_q <= out_valid_d;
			if (state_q == ilha_pkg::S_IDLE && in_valid) act_q <= action;
		end
	end

	// Next state and command
	always_comb begin
		state_d = state_q;
		fctx_d = fctx_q;
		mctx_d = mctx_q;
		cmd = ilha_pkg::CMD_NOP;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ilha_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd = ilha_pkg::CMD_LATCH;
					state_d = ilha_pkg::S_DISP;
				end
			end
			ilha_pkg::S_DISP: begin
				case (act_q)
					ilha_pkg::ACT_INIT: state_d = ilha_pkg::S_INI0;
					ilha_pkg::ACT_ALLOC: begin
						if (!st.ready) begin
							cmd = ilha_pkg::CMD_ST3;
							state_d = ilha_pkg::S_DONE;
						end else if (st.req_zero) begin
							cmd = ilha_pkg::CMD_ST1;
							state_d = ilha_pkg::S_DONE;
						end else begin
							state_d = ilha_pkg::S_SK0;
						end
					end
					ilha_pkg::ACT_FREE: begin
						if (!st.ready) begin
							cmd = ilha_pkg::CMD_ST3;
							state_d = ilha_pkg::S_DONE;
						end else begin
							state_d = ilha_pkg::S_FREE0;
						end
					end
					default: state_d = ilha_pkg::S_DONE;
				endcase
			end
			// Prologue and epilogue
			ilha_pkg::S_INI0: begin cmd = ilha_pkg::CMD_INI0; state_d = ilha_pkg::S_INI1; end
			ilha_pkg::S_INI1: begin cmd = ilha_pkg::CMD_INI1; state_d = ilha_pkg::S_INI2; end
			ilha_pkg::S_INI2: begin cmd = ilha_pkg::CMD_INI2; state_d = ilha_pkg::S_INI3; end
			ilha_pkg::S_INI3: begin
				cmd = ilha_pkg::CMD_INI3;
				mctx_d = ilha_pkg::MC_INIT;
				state_d = ilha_pkg::S_GR0;
			end
			// Grow the break
			ilha_pkg::S_GR0: begin
				cmd = ilha_pkg::CMD_GR0;
				state_d = st.grow_fail ? ilha_pkg::S_MEND : ilha_pkg::S_GR1;
			end
			ilha_pkg::S_GR1: begin cmd = ilha_pkg::CMD_GR1; state_d = ilha_pkg::S_GR2; end
			ilha_pkg::S_GR2: begin cmd = ilha_pkg::CMD_GR2; state_d = ilha_pkg::S_M0; end
			// Coalesce: read both neighbor tags
			ilha_pkg::S_M0: begin cmd = ilha_pkg::CMD_M0; state_d = ilha_pkg::S_M1; end
			ilha_pkg::S_M1: begin cmd = ilha_pkg::CMD_M1; state_d = ilha_pkg::S_M2; end
			ilha_pkg::S_M2: begin cmd = ilha_pkg::CMD_M2; state_d = ilha_pkg::S_M3; end
			ilha_pkg::S_M3: begin cmd = ilha_pkg::CMD_M3; state_d = ilha_pkg::S_M4; end
			ilha_pkg::S_M4: begin
				cmd = ilha_pkg::CMD_M4;
				fctx_d = ilha_pkg::FW_MERGE;
				if (st.pused && st.rused) state_d = ilha_pkg::S_MEND;
				else if (st.pused) state_d = ilha_pkg::S_MA;
				else if (st.rused) state_d = ilha_pkg::S_MB;
				else state_d = ilha_pkg::S_MC0;
			end
			ilha_pkg::S_MA: begin cmd = ilha_pkg::CMD_MA; state_d = ilha_pkg::S_FR; end
			ilha_pkg::S_MB: begin cmd = ilha_pkg::CMD_MB; state_d = ilha_pkg::S_FR; end
			ilha_pkg::S_MC0: begin cmd = ilha_pkg::CMD_MC0; state_d = ilha_pkg::S_MC1; end
			ilha_pkg::S_MC1: begin cmd = ilha_pkg::CMD_MC1; state_d = ilha_pkg::S_MC2; end
			ilha_pkg::S_MC2: begin cmd = ilha_pkg::CMD_MC2; state_d = ilha_pkg::S_FW; end
			// Footer update shared by every caller
			ilha_pkg::S_FR: begin cmd = ilha_pkg::CMD_FR; state_d = ilha_pkg::S_FW; end
			ilha_pkg::S_FW: begin
				cmd = ilha_pkg::CMD_FW;
				unique case (fctx_q)
					ilha_pkg::FW_MERGE: state_d = ilha_pkg::S_MEND;
					ilha_pkg::FW_FREE: begin
						mctx_d = ilha_pkg::MC_FREE;
						state_d = ilha_pkg::S_M0;
					end
					ilha_pkg::FW_CARVE_A: state_d = st.split ? ilha_pkg::S_KS0 : ilha_pkg::S_DONE;
					ilha_pkg::FW_CARVE_B: state_d = ilha_pkg::S_DONE;
					default: state_d = ilha_pkg::S_DONE;
				endcase
			end
			// End of coalesce
			ilha_pkg::S_MEND: begin
				if (mctx_q == ilha_pkg::MC_FREE) begin
					state_d = ilha_pkg::S_DONE;
				end else if (st.mret_zero) begin
					cmd = ilha_pkg::CMD_FAIL;
					state_d = ilha_pkg::S_DONE;
				end else if (mctx_q == ilha_pkg::MC_INIT) begin
					state_d = ilha_pkg::S_DONE;
				end else begin
					cmd = ilha_pkg::CMD_TAKE;
					state_d = ilha_pkg::S_K0;
				end
			end
			// Free
			ilha_pkg::S_FREE0: begin cmd = ilha_pkg::CMD_FREE0; state_d = ilha_pkg::S_FREE1; end
			ilha_pkg::S_FREE1: begin
				cmd = ilha_pkg::CMD_FREE1;
				fctx_d = ilha_pkg::FW_FREE;
				state_d = ilha_pkg::S_FR;
			end
			// First-fit walk, one header per block
			ilha_pkg::S_SK0: begin
				if (st.seek_oob) begin
					state_d = ilha_pkg::S_NF;
				end else begin
					cmd = ilha_pkg::CMD_SK0;
					state_d = ilha_pkg::S_SK1;
				end
			end
			ilha_pkg::S_SK1: begin
				cmd = ilha_pkg::CMD_SK1;
				if (st.seek_zero) state_d = ilha_pkg::S_NF;
				else if (st.seek_fit) state_d = ilha_pkg::S_K0;
				else if (st.seek_last) state_d = ilha_pkg::S_NF;
				else state_d = ilha_pkg::S_SK0;
			end
			ilha_pkg::S_NF: begin
				cmd = ilha_pkg::CMD_NF;
				mctx_d = ilha_pkg::MC_ALLOC;
				state_d = ilha_pkg::S_GR0;
			end
			// Carve
			ilha_pkg::S_K0: begin cmd = ilha_pkg::CMD_K0; state_d = ilha_pkg::S_K1; end
			ilha_pkg::S_K1: begin
				cmd = ilha_pkg::CMD_K1;
				fctx_d = ilha_pkg::FW_CARVE_A;
				state_d = ilha_pkg::S_FR;
			end
			ilha_pkg::S_KS0: begin cmd = ilha_pkg::CMD_KS0; state_d = ilha_pkg::S_KS1; end
			ilha_pkg::S_KS1: begin
				cmd = ilha_pkg::CMD_KS1;
				fctx_d = ilha_pkg::FW_CARVE_B;
				state_d = ilha_pkg::S_FR;
			end
			// Hand the result to the output register
			ilha_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd = ilha_pkg::CMD_OUT;
					out_valid_d = 1'b1;
					state_d = ilha_pkg::S_IDLE;
				end
			end
			default: state_d = ilha_pkg::S_IDLE;
		endcase
	end

endmodule

### design/ilha_dp.sv
// Datapath of the heap allocator: heap word memory, address arithmetic, work registers.
// Depends on ilha_pkg; driven by ilha_ctrl commands.
module ilha_dp #(
	parameter int HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ilha_pkg::cmd_t     cmd,
	output ilha_pkg::dp_stat_t st,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         action,
	input  logic [15:0]        request_size,
	input  logic [15:0]        block_addr,
	output logic [15:0]        result_addr,
	output logic [1:0]         status
);

	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(HEAP_BYTES / 8 + 1);
	localparam logic [31:0] HEAP_W = 32'(HEAP_BYTES);
	localparam logic [CW-1:0] WALK_LAST = CW'(HEAP_BYTES / 8);

	logic [ilha_pkg::WORD_W-1:0] mem [DEPTH];
	logic [31:0] mem_q;
	logic oob_q;

	logic [31:0] bp_q, x_q, v_q, pb_q, psz_q, nsz_q, sz_q, need_q, ext_q;
	logic [31:0] res_q, mret_q, rest_q, brk_q;
	logic [CW-1:0] cnt_q;
	logic [15:0] chunk_q;
	logic [1:0] stat_q;
	logic ready_q, pused_q, reqz_q, split_q;
	logic [15:0] out_addr_q;
	logic [1:0] out_stat_q;

	logic [31:0] rdata, rsize, cb, need_d;
	logic rused, whole_case;
	logic we, re;
	logic [31:0] waddr, raddr, wdata;

	assign rdata = oob_q ? 32'd0 : mem_q;
	assign rsize = rdata & ilha_pkg::SIZE_MASK;
	assign rused = rdata[0];
	assign whole_case = (rsize < need_q) || ((rsize - need_q) < ilha_pkg::MIN_BLOCK);

	// Chunk rounded to 8 bytes, at least one minimum block
	always_comb begin
		cb = ({16'd0, chunk_q} + 32'd7) & ilha_pkg::SIZE_MASK;
		if (cb < ilha_pkg::MIN_BLOCK) cb = ilha_pkg::MIN_BLOCK;
	end

	// Block size for a request
	always_comb begin
		if ({16'd0, request_size} <= ilha_pkg::PAIR_BYTES) need_d = 32'd2 * ilha_pkg::PAIR_BYTES;
		else need_d = ({16'd0, request_size} + ilha_pkg::PAIR_BYTES + 32'd7) & ilha_pkg::SIZE_MASK;
	end

	// Flags to the controller
	always_comb begin
		st.grow_fail = ext_q > (HEAP_W - brk_q);
		st.seek_oob = bp_q >= HEAP_W;
		st.seek_zero = (rsize == 32'd0);
		st.seek_fit = !rused && (need_q <= rsize);
		st.seek_last = (cnt_q == WALK_LAST);
		st.rused = rused;
		st.pused = pused_q;
		st.mret_zero = (mret_q == 32'd0);
		st.ready = ready_q;
		st.req_zero = reqz_q;
		st.split = split_q;
	end

	// Memory address and data per command
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = 32'd0;
		raddr = 32'd0;
		wdata = 32'd0;
		case (cmd)
			ilha_pkg::CMD_INI0: begin we = 1'b1; waddr = 32'd0; wdata = 32'd0; end
			ilha_pkg::CMD_INI1: begin
				we = 1'b1; waddr = 32'd4; wdata = ilha_pkg::PAIR_BYTES | ilha_pkg::USED_BIT;
			end
			ilha_pkg::CMD_INI2: begin
				we = 1'b1; waddr = 32'd8; wdata = ilha_pkg::PAIR_BYTES | ilha_pkg::USED_BIT;
			end
			ilha_pkg::CMD_INI3: begin we = 1'b1; waddr = 32'd12; wdata = ilha_pkg::USED_BIT; end
			ilha_pkg::CMD_GR0: begin
				we = !st.grow_fail; waddr = brk_q - ilha_pkg::WORD_BYTES; wdata = ext_q;
			end
			ilha_pkg::CMD_GR1: begin
				we = 1'b1; waddr = bp_q + ext_q - ilha_pkg::PAIR_BYTES; wdata = ext_q;
			end
			ilha_pkg::CMD_GR2: begin
				we = 1'b1; waddr = bp_q + ext_q - ilha_pkg::WORD_BYTES; wdata = ilha_pkg::USED_BIT;
			end
			ilha_pkg::CMD_M0: begin re = 1'b1; raddr = bp_q - ilha_pkg::PAIR_BYTES; end
			ilha_pkg::CMD_M1: begin re = 1'b1; raddr = bp_q - rsize - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_M2: begin re = 1'b1; raddr = bp_q - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_M3: begin re = 1'b1; raddr = bp_q + rsize - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_MA: begin
				we = 1'b1; waddr = bp_q - ilha_pkg::WORD_BYTES; wdata = sz_q + nsz_q;
			end
			ilha_pkg::CMD_MB: begin
				we = 1'b1; waddr = pb_q - ilha_pkg::WORD_BYTES; wdata = sz_q + psz_q;
			end
			ilha_pkg::CMD_MC0: begin
				we = 1'b1; waddr = pb_q - ilha_pkg::WORD_BYTES; wdata = sz_q + psz_q + nsz_q;
			end
			ilha_pkg::CMD_MC1: begin re = 1'b1; raddr = bp_q - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_MC2: begin re = 1'b1; raddr = bp_q + rsize - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_FR: begin re = 1'b1; raddr = x_q - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_FW: begin
				we = 1'b1; waddr = x_q + rsize - ilha_pkg::PAIR_BYTES; wdata = v_q;
			end
			ilha_pkg::CMD_FREE0: begin re = 1'b1; raddr = bp_q - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_FREE1: begin
				we = 1'b1; waddr = bp_q - ilha_pkg::WORD_BYTES; wdata = rsize;
			end
			ilha_pkg::CMD_SK0: begin re = 1'b1; raddr = bp_q - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_K0: begin re = 1'b1; raddr = bp_q - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_K1: begin
				we = 1'b1; waddr = bp_q - ilha_pkg::WORD_BYTES;
				wdata = (whole_case ? rsize : need_q) | ilha_pkg::USED_BIT;
			end
			ilha_pkg::CMD_KS0: begin re = 1'b1; raddr = bp_q - ilha_pkg::WORD_BYTES; end
			ilha_pkg::CMD_KS1: begin
				we = 1'b1; waddr = bp_q + rsize - ilha_pkg::WORD_BYTES; wdata = rest_q;
			end
			default: ;
		endcase
	end

	// Heap word memory; addresses past the heap read zero and drop writes
	always_ff @(posedge clk) begin
		if (we && waddr < HEAP_W) mem[waddr[IW+1:2]] <= wdata;
		if (re) begin
			mem_q <= mem[raddr[IW+1:2]];
			oob_q <= (raddr >= HEAP_W);
		end
	end

	// Control state: break, ready flag, chunk register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_q <= 32'd0;
			ready_q <= 1'b0;
			chunk_q <= ilha_pkg::CHUNK_RESET;
		end else begin
			if (cfg_we) chunk_q <= cfg_data;
			case (cmd)
				ilha_pkg::CMD_INI0: begin brk_q <= 32'd0; ready_q <= 1'b0; end
				ilha_pkg::CMD_INI3: begin brk_q <= 32'd16; ready_q <= 1'b1; end
				ilha_pkg::CMD_GR0: if (!st.grow_fail) brk_q <= brk_q + ext_q;
				default: ;
			endcase
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		case (cmd)
			ilha_pkg::CMD_LATCH: begin
				bp_q <= (action == ilha_pkg::ACT_FREE) ? {16'd0, block_addr} : ilha_pkg::PAIR_BYTES;
				need_q <= need_d;
				reqz_q <= (request_size == 16'd0);
				res_q <= 32'd0;
				stat_q <= ilha_pkg::ST_OK;
				cnt_q <= '0;
			end
			ilha_pkg::CMD_ST1: stat_q <= ilha_pkg::ST_ZERO;
			ilha_pkg::CMD_ST3: stat_q <= ilha_pkg::ST_NOINIT;
			ilha_pkg::CMD_FAIL: stat_q <= ilha_pkg::ST_OOM;
			ilha_pkg::CMD_TAKE: bp_q <= mret_q;
			ilha_pkg::CMD_INI3: ext_q <= cb;
			ilha_pkg::CMD_GR0: begin
				if (st.grow_fail) mret_q <= 32'd0;
				else bp_q <= brk_q;
			end
			ilha_pkg::CMD_M1: pb_q <= bp_q - rsize;
			ilha_pkg::CMD_M2: begin pused_q <= rused; psz_q <= rsize; end
			ilha_pkg::CMD_M3: sz_q <= rsize;
			ilha_pkg::CMD_M4: begin nsz_q <= rsize; mret_q <= bp_q; end
			ilha_pkg::CMD_MA: begin v_q <= sz_q + nsz_q; x_q <= bp_q; mret_q <= bp_q; end
			ilha_pkg::CMD_MB: begin v_q <= sz_q + psz_q; x_q <= bp_q; mret_q <= pb_q; end
			ilha_pkg::CMD_MC0: begin v_q <= sz_q + psz_q + nsz_q; mret_q <= pb_q; end
			ilha_pkg::CMD_MC2: x_q <= bp_q + rsize;
			ilha_pkg::CMD_FREE1: begin v_q <= rsize; x_q <= bp_q; end
			ilha_pkg::CMD_SK1: begin
				if (!st.seek_zero && !st.seek_fit) begin
					bp_q <= bp_q + rsize;
					cnt_q <= cnt_q + CW'(1);
				end
			end
			ilha_pkg::CMD_NF: ext_q <= (need_q > cb) ? need_q : cb;
			ilha_pkg::CMD_K0: res_q <= bp_q;
			ilha_pkg::CMD_K1: begin
				x_q <= bp_q;
				split_q <= !whole_case;
				v_q <= (whole_case ? rsize : need_q) | ilha_pkg::USED_BIT;
				rest_q <= rsize - need_q;
			end
			ilha_pkg::CMD_KS1: begin x_q <= bp_q + rsize; v_q <= rest_q; end
			ilha_pkg::CMD_OUT: begin out_addr_q <= res_q[15:0]; out_stat_q <= stat_q; end
			default: ;
		endcase
	end

	assign result_addr = out_addr_q;
	assign status = out_stat_q;

endmodule
